FILE: sv/assert_macros.svh
// assertion macros for the histogram block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);
`endif

FILE: sv/mbarh_pkg.sv
// types and constants for the mass binned axis ratio histogram
package mbarh_pkg;
    localparam int unsigned SCALE_W = 32;
    localparam int unsigned AXIS_W = 32;
    localparam int unsigned COUNT_W = 24;
    localparam int unsigned SUM_W = 48;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned FRAC_W = 16;
    localparam logic FUNC_ADD = 1'b0;
    localparam logic FUNC_READ = 1'b1;
    localparam logic [5:0] SLOT_COUNT = 6'd0;
    localparam logic [5:0] SLOT_SUM_LO = 6'd1;
    localparam logic [5:0] SLOT_CELL_LO = 6'd4;

    typedef struct packed {
        logic        func;
        logic [23:0] particle_count;
        logic [31:0] axis_a;
        logic [31:0] axis_b;
        logic [31:0] axis_c;
        logic [3:0]  read_bin;
        logic [5:0]  read_slot;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  bin_index;
        logic [47:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } div_rsp_t;
endpackage

FILE: sv/mbarh_div.sv
// iterative restoring divider for saturated q16.16 ratios
module mbarh_div
    import mbarh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    localparam int unsigned QW = 48;
    logic [QW-1:0] rem_reg, rem_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [QW:0] trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[QW-1]} - {17'd0, den_reg};
        if (req.start)
        begin
            rem_next = '0;
            quo_next = {req.num, 16'd0};
            den_next = req.den;
            cnt_next = 6'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[QW])
            begin
                rem_next = trial[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[QW-2:0], quo_reg[QW-1]};
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo = (quo_reg[QW-1:32] != '0) ? 32'hFFFF_FFFF : quo_reg[31:0];
endmodule

FILE: sv/mbarh_store.sv
// histogram word memory with clearing pass, a registered read port and a write port
module mbarh_store
    import mbarh_pkg::*;
#(
    parameter int unsigned DEPTH = 704,
    parameter int unsigned AW = 10
)
(
    input  logic          clk,
    input  logic          rst_n,
    output logic          clear_done,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [47:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [47:0]   wr_data
);
    logic [47:0] mem [DEPTH];
    logic [AW:0] clr_reg, clr_next;
    logic        clearing;
    logic        we;
    logic [AW-1:0] wa;
    logic [47:0] wd;

    assign clearing = (clr_reg != (AW+1)'(DEPTH));
    assign clr_next = clearing ? clr_reg + (AW+1)'(1) : clr_reg;
    assign clear_done = !clearing;
    assign we = clearing ? 1'b1 : wr_en;
    assign wa = clearing ? clr_reg[AW-1:0] : wr_addr;
    assign wd = clearing ? '0 : wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else
            clr_reg <= clr_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end
endmodule

FILE: sv/mass_binned_axis_ratio_histogram.sv
// Per-bin halo count, three 48-bit ratio sums and 2*CELLS ratio cells live in
// one single-port-read memory of BINS*(4+2*CELLS) words, cleared after reset
// by a pass over all BINS*(4+2*CELLS) words (704 at defaults) during which no
// item is taken. An add item with all axes nonzero runs three divisions on
// one shared divider, then six read-modify-writes. An add item with a zero
// axis skips the divisions and the updates and only reports its bin.
`include "assert_macros.svh"
module mass_binned_axis_ratio_histogram
    import mbarh_pkg::*;
#(
    parameter int unsigned BINS = 16,
    parameter int unsigned CELLS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);
    localparam int unsigned SLOTS = 4 + 2 * CELLS;
    localparam int unsigned DEPTH = BINS * SLOTS;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned BW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int unsigned CW = $clog2(CELLS);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL   = 9'b000000010,
        ST_BIN   = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_RD    = 9'b000010000,
        ST_WR    = 9'b000100000,
        ST_RDATA = 9'b001000000,
        ST_OUT   = 9'b010000000,
        ST_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [31:0] scale_reg;
    in_item_t item_reg;
    logic [55:0] prod_reg;
    logic [BW-1:0] bin_reg;
    logic [1:0] div_idx_reg;
    logic [31:0] ac_reg, bc_reg, ab_reg;
    logic [2:0] op_reg;
    logic ok_reg;
    out_item_t out_reg;
    logic out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    logic clear_done;
    logic rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [47:0] rd_data, wr_data;

    mbarh_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    mbarh_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .clk(clk), .rst_n(rst_n), .clear_done(clear_done),
        .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    // highest set bit of product minus 16, clamped
    logic [6:0] top;
    logic found;
    logic [BW-1:0] bin_calc;
    always_comb
    begin
        top = '0;
        found = 1'b0;
        for (int k = 0; k < 56; k++)
        begin
            if (prod_reg[k])
            begin
                top = 7'(k);
                found = 1'b1;
            end
        end
        if (!found || top < 7'(FRAC_W))
            bin_calc = '0;
        else if (32'(top - 7'(FRAC_W)) >= BINS)
            bin_calc = BW'(BINS - 1);
        else
            bin_calc = BW'(top - 7'(FRAC_W));
    end

    function automatic logic [CW-1:0] cell_of(input logic [31:0] r);
        logic [39:0] m;
        m = 40'(r) * 40'(CELLS);
        if (m[39:16] >= 24'(CELLS))
            return CW'(CELLS - 1);
        return CW'(m[39:16]);
    endfunction

    logic [AW-1:0] base;
    assign base = AW'(32'(bin_reg) * SLOTS);

    logic [AW-1:0] op_addr;
    always_comb
    begin
        case (op_reg)
            3'd0: op_addr = base;
            3'd1: op_addr = base + AW'(1);
            3'd2: op_addr = base + AW'(2);
            3'd3: op_addr = base + AW'(3);
            3'd4: op_addr = base + AW'(4) + AW'(cell_of(ac_reg));
            default: op_addr = base + AW'(4 + CELLS) + AW'(cell_of(bc_reg));
        endcase
    end

    logic [48:0] sum;
    logic [47:0] upd;
    always_comb
    begin
        sum = '0;
        case (op_reg)
            3'd1: sum = {1'b0, rd_data} + 49'(ac_reg);
            3'd2: sum = {1'b0, rd_data} + 49'(bc_reg);
            3'd3: sum = {1'b0, rd_data} + 49'(ab_reg);
            default: sum = '0;
        endcase
        if (op_reg == 3'd1 || op_reg == 3'd2 || op_reg == 3'd3)
            upd = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        else
            upd = (rd_data[31:0] == 32'hFFFF_FFFF) ? rd_data : rd_data + 48'd1;
    end

    logic read_ok;
    assign read_ok = (32'(item_reg.read_bin) < BINS) && (32'(item_reg.read_slot) < SLOTS);

    assign in_ready = (state_reg == ST_IDLE) && clear_done;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign rd_en = (state_reg == ST_RD) ||
                   (state_reg == ST_MUL && item_reg.func == FUNC_READ);
    assign rd_addr = (state_reg == ST_RD) ? op_addr :
                     AW'(32'(item_reg.read_bin) * SLOTS + 32'(item_reg.read_slot));
    assign wr_en = (state_reg == ST_WR);
    assign wr_addr = op_addr;
    assign wr_data = upd;

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num = item_reg.axis_a;
        dreq.den = item_reg.axis_c;
        if (state_reg == ST_BIN && ok_reg)
            dreq.start = 1'b1;
        else if (state_reg == ST_DIV && drsp.done && div_idx_reg != 2'd2)
        begin
            dreq.start = 1'b1;
            if (div_idx_reg == 2'd0)
            begin
                dreq.num = item_reg.axis_b;
            end
            else
            begin
                dreq.num = item_reg.axis_a;
                dreq.den = item_reg.axis_b;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && in_ready) state_next = ST_MUL;
            ST_MUL:   state_next = (item_reg.func == FUNC_READ) ? ST_RDATA : ST_BIN;
            ST_BIN:   state_next = ok_reg ? ST_DIV : ST_OUT;
            ST_DIV:   if (drsp.done && div_idx_reg == 2'd2) state_next = ST_RD;
            ST_RD:    state_next = ST_WR;
            ST_WR:    state_next = (op_reg == 3'd5) ? ST_OUT : ST_RD;
            ST_RDATA: state_next = ST_OUT;
            ST_OUT:   state_next = ST_WAIT;
            ST_WAIT:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scale_reg <= 32'd65536;
            out_valid_reg <= 1'b0;
            div_idx_reg <= '0;
            op_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                scale_reg <= cfg_data;
            if (state_reg == ST_WAIT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_BIN)
                div_idx_reg <= '0;
            else if (state_reg == ST_DIV && drsp.done)
                div_idx_reg <= div_idx_reg + 2'd1;
            if (state_reg == ST_BIN)
                op_reg <= '0;
            else if (state_reg == ST_WR)
                op_reg <= op_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == ST_MUL)
        begin
            prod_reg <= 56'(item_reg.particle_count) * 56'(scale_reg);
            ok_reg <= (item_reg.axis_a != '0) && (item_reg.axis_b != '0) &&
                      (item_reg.axis_c != '0);
        end
        if (state_reg == ST_BIN)
        begin
            bin_reg <= bin_calc;
            out_reg.accepted <= ok_reg;
            out_reg.bin_index <= 4'(bin_calc);
            out_reg.read_value <= '0;
        end
        if (state_reg == ST_DIV && drsp.done)
        begin
            case (div_idx_reg)
                2'd0: ac_reg <= drsp.quo;
                2'd1: bc_reg <= drsp.quo;
                default: ab_reg <= drsp.quo;
            endcase
        end
        if (state_reg == ST_RDATA)
        begin
            out_reg.accepted <= 1'b0;
            out_reg.bin_index <= item_reg.read_bin;
            out_reg.read_value <= read_ok ? rd_data : '0;
        end
        if (state_reg == ST_WAIT && (!out_valid_reg || out_ready))
            out_data <= out_reg;
    end

    assign out_valid = out_valid_reg;

    `ASSERT_IMPL(a_no_in_when_busy, clk, rst_n,
        (in_valid && in_ready) |=> (state_reg == ST_MUL), "accept did not start work")
    `ASSERT_NEVER(a_no_wr_clearing, clk, rst_n,
        (wr_en && !clear_done), "update during clearing pass")
    `ASSERT_NEVER(a_no_cfg_busy, clk, rst_n,
        (cfg_ready && state_reg != ST_IDLE), "config while busy")
endmodule
